// File: hw/rtl/psgp_pkg.sv
// package: shared types and constants of the periodic slot greedy placer
`timescale 1ns / 1ps
package psgp_pkg;

	localparam int DELAY_W = 6;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 8;
	localparam int PERIOD_W = 7;
	localparam int OUT_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHOICE = 8'd1;

	localparam logic [PERIOD_W-1:0] PERIOD_RST = 7'd64;

	localparam logic RULE_FIRST_FIT = 1'b0;
	localparam logic RULE_POTENTIAL = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD_WAIT,
		ST_PREP_RD,
		ST_PREP_GO,
		ST_PREP_WAIT,
		ST_CLEAR,
		ST_ROUTE_RD,
		ST_ROUTE_D,
		ST_SLOT_RD,
		ST_SLOT_CHK,
		ST_J_TEST,
		ST_J_DJ,
		ST_J_ACC,
		ST_J_END,
		ST_WRITE,
		ST_EMIT
	} state_t;

endpackage

// File: hw/rtl/psgp_mod.sv
// shared iterative remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps
module psgp_mod #(
	parameter int PW = 7
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [psgp_pkg::DELAY_W-1:0] x,
	input  logic [PW-1:0]                m,
	output logic                         done,
	output logic [PW-1:0]                res
);

	localparam int SW = (psgp_pkg::DELAY_W > 1) ? $clog2(psgp_pkg::DELAY_W) : 1;

	logic                         busy_q;
	logic                         done_q;
	logic [SW-1:0]                step_q;
	logic [psgp_pkg::DELAY_W-1:0] x_q;
	logic [PW-1:0]                m_q;
	logic [PW-1:0]                rem_q;
	logic [PW:0]                  trial;
	logic [PW-1:0]                rem_nx;

	always_comb begin
		trial = {rem_q, x_q[psgp_pkg::DELAY_W-1]};
		if (trial >= {1'b0, m_q}) begin
			rem_nx = PW'(trial - {1'b0, m_q});
		end else begin
			rem_nx = trial[PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= SW'(psgp_pkg::DELAY_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			m_q   <= m;
			rem_q <= '0;
		end else if (busy_q) begin
			x_q   <= {x_q[psgp_pkg::DELAY_W-2:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign res  = rem_q;

endmodule

// File: hw/rtl/psgp_map.sv
// one-bit slot map memory with registered read
`timescale 1ns / 1ps
module psgp_map #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [DEPTH];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/periodic_slot_greedy_placer.sv
// top level: route store, sequencer and slot maps of the periodic slot greedy placer
`timescale 1ns / 1ps
// Each route item is accepted, then the shared 6-step remainder unit reduces its delay
// modulo the period before it is stored. The item with tlast starts placement: the stored
// delays are reduced again one route at a time, the slot maps are cleared slot by slot,
// then each route tries its slots in turn, waiting while the output register stays
// full; in potential mode each free slot is scored against every later route.
// Results leave one per route through an output register; no item is taken until
// placement has finished.
module periodic_slot_greedy_placer #(
	parameter int MAX_PERIOD = 64,
	parameter int MAX_ROUTES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [psgp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [psgp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // route_delay[5:0]
	input  logic                           s_tlast,  // last_route
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// route_index[3:0], placed[4], slot[10:5], placed_total[15:11]
	output logic [psgp_pkg::OUT_W-1:0]     m_tdata,
	output logic                           m_tlast   // last_result
);

	localparam int PW  = $clog2(MAX_PERIOD + 1);
	localparam int AW  = $clog2(MAX_PERIOD);
	localparam int IW  = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
	localparam int CW  = $clog2(MAX_ROUTES + 1);
	localparam int SCW = $clog2(2 * MAX_ROUTES + 1);
	localparam int EW  = (PW > psgp_pkg::PERIOD_W) ? PW : psgp_pkg::PERIOD_W;
	localparam int DW  = psgp_pkg::DELAY_W;

	psgp_pkg::state_t state_q, state_nx;

	logic [psgp_pkg::PERIOD_W-1:0] period_q;
	logic                          rule_q;
	logic [PW-1:0]                 p_eff;
	logic [EW-1:0]                 p_ext;

	logic [DW-1:0] store [MAX_ROUTES];
	logic [DW-1:0] sdata_q;
	logic          st_we;
	logic [IW-1:0] st_waddr;
	logic [DW-1:0] st_wdata;
	logic [IW-1:0] st_raddr;

	logic [CW-1:0]  cnt_q, k_q, r_q, j_q, total_q;
	logic           last_q;
	logic [AW-1:0]  clr_q, s_q, t_q, best_q;
	logic [DW-1:0]  d_q;
	logic           bestv_q;
	logic [SCW-1:0] score_q, bscore_q;
	logic           out_valid_q;
	logic [psgp_pkg::OUT_W-1:0] out_data_q;
	logic           out_last_q;

	logic          mod_start, mod_done;
	logic [DW-1:0] mod_x;
	logic [PW-1:0] mod_res;

	logic          f_we, r_we, f_wd, r_wd, f_rd, r_rd;
	logic [AW-1:0] f_wa, r_wa, f_ra, r_ra;

	logic in_acc, out_free, s_last, free_slot, take;

	function automatic logic [AW-1:0] wrap(input logic [PW:0] v, input logic [PW-1:0] pp);
		logic [AW-1:0] w;
		if (v >= {1'b0, pp}) begin
			w = AW'(v - {1'b0, pp});
		end else begin
			w = AW'(v);
		end
		return w;
	endfunction

	always_comb begin
		p_ext = EW'(period_q);
		if (p_ext == '0) begin
			p_eff = PW'(1);
		end else if (p_ext > EW'(MAX_PERIOD)) begin
			p_eff = PW'(MAX_PERIOD);
		end else begin
			p_eff = PW'(p_ext);
		end
	end

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == psgp_pkg::ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign s_last    = (PW'(s_q) == p_eff - PW'(1));
	assign free_slot = !f_rd && !r_rd;
	assign take      = !bestv_q || (score_q > bscore_q);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			psgp_pkg::ST_IDLE: begin
				if (in_acc) state_nx = psgp_pkg::ST_LOAD_WAIT;
			end
			psgp_pkg::ST_LOAD_WAIT: begin
				if (mod_done) state_nx = last_q ? psgp_pkg::ST_PREP_RD : psgp_pkg::ST_IDLE;
			end
			psgp_pkg::ST_PREP_RD: state_nx = psgp_pkg::ST_PREP_GO;
			psgp_pkg::ST_PREP_GO: state_nx = psgp_pkg::ST_PREP_WAIT;
			psgp_pkg::ST_PREP_WAIT: begin
				if (mod_done) begin
					state_nx = (k_q + CW'(1) == cnt_q) ? psgp_pkg::ST_CLEAR : psgp_pkg::ST_PREP_RD;
				end
			end
			psgp_pkg::ST_CLEAR: begin
				if (PW'(clr_q) == p_eff - PW'(1)) state_nx = psgp_pkg::ST_ROUTE_RD;
			end
			psgp_pkg::ST_ROUTE_RD: state_nx = psgp_pkg::ST_ROUTE_D;
			psgp_pkg::ST_ROUTE_D: state_nx = psgp_pkg::ST_SLOT_RD;
			psgp_pkg::ST_SLOT_RD: state_nx = psgp_pkg::ST_SLOT_CHK;
			psgp_pkg::ST_SLOT_CHK: begin
				if (free_slot && rule_q == psgp_pkg::RULE_FIRST_FIT) begin
					state_nx = psgp_pkg::ST_WRITE;
				end else if (free_slot) begin
					state_nx = psgp_pkg::ST_J_TEST;
				end else if (s_last) begin
					state_nx = psgp_pkg::ST_WRITE;
				end else begin
					state_nx = psgp_pkg::ST_SLOT_RD;
				end
			end
			psgp_pkg::ST_J_TEST: begin
				state_nx = (j_q < cnt_q) ? psgp_pkg::ST_J_DJ : psgp_pkg::ST_J_END;
			end
			psgp_pkg::ST_J_DJ: state_nx = psgp_pkg::ST_J_ACC;
			psgp_pkg::ST_J_ACC: state_nx = psgp_pkg::ST_J_TEST;
			psgp_pkg::ST_J_END: state_nx = s_last ? psgp_pkg::ST_WRITE : psgp_pkg::ST_SLOT_RD;
			psgp_pkg::ST_WRITE: state_nx = psgp_pkg::ST_EMIT;
			psgp_pkg::ST_EMIT: begin
				if (out_free) begin
					state_nx = (r_q + CW'(1) == cnt_q) ? psgp_pkg::ST_IDLE : psgp_pkg::ST_ROUTE_RD;
				end
			end
			default: state_nx = psgp_pkg::ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		mod_start = 1'b0;
		mod_x     = s_tdata[DW-1:0];
		st_we     = 1'b0;
		st_waddr  = cnt_q[IW-1:0];
		st_wdata  = DW'(mod_res);
		st_raddr  = k_q[IW-1:0];
		f_we = 1'b0;
		r_we = 1'b0;
		f_wd = 1'b0;
		r_wd = 1'b0;
		f_wa = clr_q;
		r_wa = clr_q;
		f_ra = s_q;
		r_ra = wrap((PW+1)'(s_q) + (PW+1)'(d_q), p_eff);
		case (state_q)
			psgp_pkg::ST_IDLE: mod_start = in_acc;
			psgp_pkg::ST_LOAD_WAIT: st_we = mod_done && (cnt_q < CW'(MAX_ROUTES));
			psgp_pkg::ST_PREP_GO: begin
				mod_start = 1'b1;
				mod_x     = sdata_q;
			end
			psgp_pkg::ST_PREP_WAIT: begin
				st_we    = mod_done;
				st_waddr = k_q[IW-1:0];
			end
			psgp_pkg::ST_CLEAR: begin
				f_we = 1'b1;
				r_we = 1'b1;
			end
			psgp_pkg::ST_ROUTE_RD: st_raddr = r_q[IW-1:0];
			psgp_pkg::ST_J_TEST: st_raddr = j_q[IW-1:0];
			psgp_pkg::ST_J_DJ: begin
				r_ra = wrap((PW+1)'(s_q) + (PW+1)'(sdata_q), p_eff);
				f_ra = wrap((PW+1)'(t_q) + (PW+1)'(p_eff) - (PW+1)'(sdata_q), p_eff);
			end
			psgp_pkg::ST_WRITE: begin
				f_we = bestv_q;
				r_we = bestv_q;
				f_wd = 1'b1;
				r_wd = 1'b1;
				f_wa = best_q;
				r_wa = wrap((PW+1)'(best_q) + (PW+1)'(d_q), p_eff);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= psgp_pkg::ST_IDLE;
			period_q    <= psgp_pkg::PERIOD_RST;
			rule_q      <= psgp_pkg::RULE_FIRST_FIT;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					psgp_pkg::REG_PERIOD: period_q <= cfg_data[psgp_pkg::PERIOD_W-1:0];
					psgp_pkg::REG_CHOICE: rule_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (state_q == psgp_pkg::ST_LOAD_WAIT && mod_done && cnt_q < CW'(MAX_ROUTES)) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (state_q == psgp_pkg::ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
				if (r_q + CW'(1) == cnt_q) cnt_q <= '0;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store[st_waddr] <= st_wdata;
		end
		sdata_q <= store[st_raddr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			psgp_pkg::ST_IDLE: last_q <= s_tlast;
			psgp_pkg::ST_LOAD_WAIT: begin
				k_q   <= '0;
				clr_q <= '0;
			end
			psgp_pkg::ST_PREP_WAIT: if (mod_done) k_q <= k_q + CW'(1);
			psgp_pkg::ST_CLEAR: begin
				clr_q   <= clr_q + AW'(1);
				r_q     <= '0;
				total_q <= '0;
			end
			psgp_pkg::ST_ROUTE_D: begin
				d_q     <= sdata_q;
				s_q     <= '0;
				bestv_q <= 1'b0;
				best_q  <= '0;
			end
			psgp_pkg::ST_SLOT_RD: t_q <= r_ra;
			psgp_pkg::ST_SLOT_CHK: begin
				score_q <= '0;
				j_q     <= r_q + CW'(1);
				if (free_slot && rule_q == psgp_pkg::RULE_FIRST_FIT) begin
					bestv_q <= 1'b1;
					best_q  <= s_q;
				end else if (!free_slot && !s_last) begin
					s_q <= s_q + AW'(1);
				end
			end
			psgp_pkg::ST_J_ACC: begin
				score_q <= score_q + SCW'(f_rd) + SCW'(r_rd);
				j_q     <= j_q + CW'(1);
			end
			psgp_pkg::ST_J_END: begin
				if (take) begin
					bestv_q  <= 1'b1;
					best_q   <= s_q;
					bscore_q <= score_q;
				end
				if (!s_last) s_q <= s_q + AW'(1);
			end
			psgp_pkg::ST_WRITE: if (bestv_q) total_q <= total_q + CW'(1);
			psgp_pkg::ST_EMIT: begin
				if (out_free) begin
					out_data_q <= {5'(total_q), bestv_q ? 6'(best_q) : 6'd0, bestv_q, 4'(r_q)};
					out_last_q <= (r_q + CW'(1) == cnt_q);
					r_q        <= r_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	psgp_mod #(.PW(PW)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.x      (mod_x),
		.m      (state_q == psgp_pkg::ST_IDLE || state_q == psgp_pkg::ST_PREP_GO ? p_eff : p_eff),
		.done   (mod_done),
		.res    (mod_res)
	);

	psgp_map #(.DEPTH(MAX_PERIOD), .AW(AW)) u_fwd (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_wa),
		.wdata (f_wd),
		.raddr (f_ra),
		.rdata (f_rd)
	);

	psgp_map #(.DEPTH(MAX_PERIOD), .AW(AW)) u_ret (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_wa),
		.wdata (r_wd),
		.raddr (r_ra),
		.rdata (r_rd)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ROUTES))
		else $error("route count beyond store size");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == psgp_pkg::ST_EMIT) |-> ((CW+1)'(total_q) <= (CW+1)'(r_q) + (CW+1)'(1)))
		else $error("placed total exceeds routes handled");

	a_score_rule: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == psgp_pkg::ST_J_ACC) |-> (rule_q == psgp_pkg::RULE_POTENTIAL))
		else $error("score pass in first-fit mode");

	a_mod_done: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == psgp_pkg::ST_LOAD_WAIT || state_q == psgp_pkg::ST_PREP_WAIT))
		else $error("remainder finished outside a wait state");

endmodule

// File: tb/periodic_slot_greedy_placer_tb.sv
// testbench: random and directed route sets against a placement predictor with scoreboard
`timescale 1ns / 1ps
module periodic_slot_greedy_placer_tb;

	localparam int MAXP = 64;
	localparam int MAXR = 16;
	localparam int WATCHDOG = 200000;

	typedef struct packed {
		logic [4:0] total;
		logic [5:0] slot;
		logic       placed;
		logic [3:0] idx;
		logic       last;
	} placement_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [psgp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [psgp_pkg::CFG_DATA_W-1:0] cfg_data;
	logic s_tvalid, s_tready, s_tlast;
	logic [7:0] s_tdata;
	logic m_tvalid, m_tready, m_tlast;
	logic [psgp_pkg::OUT_W-1:0] m_tdata;

	periodic_slot_greedy_placer DUT (.*);

	// predictor state
	logic [6:0] cur_period;
	logic       cur_rule;
	logic [5:0] route_delays [MAXR];
	int         routes_loaded;
	placement_t placements_due [$];

	int errors, items_sent, results_seen, sets_done;
	int send_idle_pct, recv_idle_pct;
	bit hold_off;
	int quiet_cycles;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic int eff_period();
		if (cur_period < 1) return 1;
		if (cur_period > MAXP) return MAXP;
		return int'(cur_period);
	endfunction

	task automatic place_routes();
		int p, n, s, j, d, dj, best, best_score, score, total;
		bit fwd [MAXP];
		bit ret [MAXP];
		placement_t pl;
		p = eff_period();
		n = routes_loaded;
		total = 0;
		for (int k = 0; k < MAXP; k++) begin
			fwd[k] = 0;
			ret[k] = 0;
		end
		for (int r = 0; r < n; r++) begin
			d = route_delays[r] % p;
			best = p;
			best_score = -1;
			for (s = 0; s < p; s++) begin
				if (fwd[s] || ret[(s + d) % p]) continue;
				if (cur_rule == psgp_pkg::RULE_FIRST_FIT) begin
					best = s;
					break;
				end
				score = 0;
				for (j = r + 1; j < n; j++) begin
					dj = route_delays[j] % p;
					score += int'(ret[(s + dj) % p]);
					score += int'(fwd[(s + d + p - dj) % p]);
				end
				if (score > best_score) begin
					best_score = score;
					best = s;
				end
			end
			pl.idx = 4'(r);
			pl.placed = best < p;
			if (best < p) begin
				fwd[best] = 1;
				ret[(best + d) % p] = 1;
				total++;
			end
			pl.slot = (best < p) ? 6'(best) : 6'd0;
			pl.total = 5'(total);
			pl.last = (r + 1 == n);
			placements_due.push_back(pl);
		end
		routes_loaded = 0;
		sets_done++;
	endtask

	task automatic load_route(input logic [5:0] dly, input logic last);
		if (routes_loaded < MAXR) begin
			route_delays[routes_loaded] = 6'(int'(dly) % eff_period());
			routes_loaded++;
		end
		if (last) place_routes();
	endtask

	task automatic send_route(input logic [5:0] dly, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {2'b00, dly};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		load_route(dly, last);
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (placements_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [psgp_pkg::CFG_IDX_W-1:0] idx,
			input logic [psgp_pkg::CFG_DATA_W-1:0] val);
		drain();
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		if (idx == psgp_pkg::REG_PERIOD) cur_period = val[6:0];
		else if (idx == psgp_pkg::REG_CHOICE) cur_rule = val[0];
	endtask

	task automatic send_set(input int n);
		for (int i = 0; i < n; i++)
			send_route(6'($urandom_range(63)), i == n - 1);
	endtask

	// receiver
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				placement_t got, want;
				got.idx = m_tdata[3:0];
				got.placed = m_tdata[4];
				got.slot = m_tdata[10:5];
				got.total = m_tdata[15:11];
				got.last = m_tlast;
				results_seen++;
				if (placements_due.size() == 0) begin
					$display("%0t unexpected result exp none act %h", $time, got);
					errors++;
				end else begin
					want = placements_due.pop_front();
					if (got != want) begin
						$display("%0t mismatch exp idx=%0d pl=%0d slot=%0d tot=%0d last=%0d",
							$time, want.idx, want.placed, want.slot, want.total, want.last,
							" act idx=%0d pl=%0d slot=%0d tot=%0d last=%0d",
							got.idx, got.placed, got.slot, got.total, got.last);
						errors++;
					end
				end
			end
			m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end else begin
			m_tready <= 0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic test_directed();
		write_reg(psgp_pkg::REG_PERIOD, 8'd64);
		write_reg(psgp_pkg::REG_CHOICE, 8'(psgp_pkg::RULE_FIRST_FIT));
		send_route(6'd0, 1);
		send_route(6'd63, 0);
		send_route(6'd0, 0);
		send_route(6'd63, 1);
		write_reg(psgp_pkg::REG_PERIOD, 8'd1);
		send_route(6'd63, 0);
		send_route(6'd5, 1);
		write_reg(psgp_pkg::REG_PERIOD, 8'd0);
		send_route(6'd42, 0);
		send_route(6'd21, 1);
		write_reg(psgp_pkg::REG_PERIOD, 8'd127);
		send_route(6'd63, 0);
		send_route(6'd1, 1);
		// period shrinks between load and placement
		write_reg(psgp_pkg::REG_PERIOD, 8'd64);
		send_route(6'd63, 0);
		send_route(6'd40, 0);
		write_reg(psgp_pkg::REG_PERIOD, 8'd5);
		send_route(6'd13, 1);
		write_reg(psgp_pkg::REG_PERIOD, 8'd7);
		write_reg(psgp_pkg::REG_CHOICE, 8'(psgp_pkg::RULE_POTENTIAL));
		send_route(6'd3, 0);
		send_route(6'd5, 0);
		send_route(6'd6, 0);
		send_route(6'd2, 1);
		// store overflow
		write_reg(psgp_pkg::REG_PERIOD, 8'd4);
		for (int i = 0; i < 18; i++) send_route(6'(i * 7), i == 17);
		write_reg(psgp_pkg::REG_CHOICE, 8'(psgp_pkg::RULE_FIRST_FIT));
		write_reg(8'd9, 8'hff);
		send_route(6'd2, 1);
	endtask

	task automatic test_random(input int budget);
		int n;
		while (budget > 0) begin
			if ($urandom_range(5) == 0)
				write_reg(psgp_pkg::REG_PERIOD, 8'($urandom_range(1, 64)));
			if ($urandom_range(5) == 0)
				write_reg(psgp_pkg::REG_CHOICE, 8'($urandom_range(1)));
			if ($urandom_range(9) == 0)
				write_reg(psgp_pkg::REG_PERIOD, $urandom_range(1) ? 8'd64 : 8'd1);
			n = ($urandom_range(15) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 8);
			send_set(n);
			budget -= n;
		end
	endtask

	task automatic test_backpressure();
		write_reg(psgp_pkg::REG_PERIOD, 8'd16);
		hold_off = 1;
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_off = 0;
			end
			begin
				send_set(6);
				send_set(5);
				drain();
			end
		join
	endtask

	initial begin
		arst_n = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		s_tvalid = 0; s_tdata = 0; s_tlast = 0;
		cur_period = psgp_pkg::PERIOD_RST;
		cur_rule = psgp_pkg::RULE_FIRST_FIT;
		routes_loaded = 0;
		errors = 0; items_sent = 0; results_seen = 0; sets_done = 0;
		hold_off = 0;
		send_idle_pct = 11; recv_idle_pct = 85;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);
		test_directed();
		test_random(120);
		send_idle_pct = 85; recv_idle_pct = 11;
		test_random(120);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_backpressure();
		test_random(120);
		drain();
		$display("covered %0d route items in %0d sets, %0d placements checked",
			items_sent, sets_done, results_seen);
		$display("periods 0..127 incl. extremes, both rules, store overflow, output back-pressure");
		if (errors == 0 && placements_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// File: sim.f
hw/rtl/psgp_pkg.sv
hw/rtl/psgp_mod.sv
hw/rtl/psgp_map.sv
hw/rtl/periodic_slot_greedy_placer.sv
tb/periodic_slot_greedy_placer_tb.sv
